>>> hdl/wknv_pkg.sv
// ----------------------------------------------------------------------------
// wknv_pkg
// Shared types and constants for the windowed nearest-neighbor search.
// ----------------------------------------------------------------------------
package wknv_pkg;

  // Default sizes for the top-level parameters.
  localparam int MAX_K_DEF      = 8;
  localparam int COORD_BITS_DEF = 10;
  localparam int MAX_RADIUS_DEF = 63;

  // Fixed field widths.
  localparam int VALUE_W  = 32;
  localparam int DIST_W   = 13;
  localparam int RANK_W   = 3;
  localparam int RADIUS_W = 6;
  localparam int COUNT_W  = 4;

  // A Q16.16 value with a raw magnitude below this counts as zero.
  localparam logic signed [VALUE_W-1:0] ZERO_LIMIT = 32'sd7;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_ROW     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_COL     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEARCH_RADIUS  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NEIGHBOR_COUNT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SKIP_ZEROS     = 3'd4;

  localparam logic [RADIUS_W-1:0] SEARCH_RADIUS_RST  = 6'd8;
  localparam logic [COUNT_W-1:0]  NEIGHBOR_COUNT_RST = 4'd4;

  // One entry of the sorted neighbor list.
  typedef struct packed {
    logic                      valid;
    logic [DIST_W-1:0]         sq_dist;
    logic signed [VALUE_W-1:0] value;
  } entry_t;

endpackage

>>> hdl/wknv_cell.sv
// ----------------------------------------------------------------------------
// wknv_cell
// One slot of the sorted insertion chain: keeps its entry, takes the new
// candidate or its left neighbor's entry when an insertion lands at or
// before it.
// ----------------------------------------------------------------------------
module wknv_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          insert,
  input  logic                          clear,
  input  logic [wknv_pkg::DIST_W-1:0]   cand_dist,
  input  logic signed [wknv_pkg::VALUE_W-1:0] cand_value,
  input  wknv_pkg::entry_t              left_entry,
  input  logic                          left_goes,
  output wknv_pkg::entry_t              entry,
  output logic                          goes,
  output wknv_pkg::entry_t              entry_nxt
);
  import wknv_pkg::*;

  entry_t entry_r;

  // The candidate ranks before this slot when the slot is empty or holds a
  // strictly larger distance; equal distances keep the earlier arrival.
  assign goes = !entry_r.valid || (entry_r.sq_dist > cand_dist);

  always_comb begin
    entry_nxt = entry_r;
    if (insert && goes) begin
      if (left_goes) begin
        entry_nxt = left_entry;
      end else begin
        entry_nxt.valid   = 1'b1;
        entry_nxt.sq_dist = cand_dist;
        entry_nxt.value   = cand_value;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_r.valid <= 1'b0;
    end else if (clear) begin
      entry_r.valid <= 1'b0;
    end else begin
      entry_r.valid <= entry_nxt.valid;
    end
    entry_r.sq_dist <= entry_nxt.sq_dist;
    entry_r.value   <= entry_nxt.value;
  end

  assign entry = entry_r;

endmodule

>>> hdl/wknv_drain.sv
// ----------------------------------------------------------------------------
// wknv_drain
// Holds a snapshot of the finished list and shifts it out, one result beat
// per cycle while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module wknv_drain #(
  parameter int MAX_K = wknv_pkg::MAX_K_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                load,
  input  logic [MAX_K-1:0]                    load_keep,
  input  logic signed [wknv_pkg::VALUE_W-1:0] load_value [MAX_K],
  input  logic                                load_none,
  output logic                                busy,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [wknv_pkg::VALUE_W-1:0] out_neighbor_value,
  output logic [wknv_pkg::RANK_W-1:0]         out_neighbor_rank,
  output logic                                out_none_found,
  output logic                                out_last_result
);
  import wknv_pkg::*;

  logic [MAX_K-1:0]          keep_r;
  logic signed [VALUE_W-1:0] snap_r [MAX_K];
  logic                      none_r;
  logic [RANK_W-1:0]         rank_r;
  logic                      out_valid_r;
  logic signed [VALUE_W-1:0] value_r;
  logic [RANK_W-1:0]         out_rank_r;
  logic                      out_none_r;
  logic                      out_last_r;
  logic                      adv;
  logic                      head_last;
  logic [MAX_K-1:0]          keep_shift;

  assign busy = |keep_r;
  assign adv  = keep_r[0] && (!out_valid_r || out_ready);

  generate
    if (MAX_K == 1) begin : g_one
      assign head_last  = 1'b1;
      assign keep_shift = '0;
    end else begin : g_many
      assign head_last  = !keep_r[1];
      assign keep_shift = {1'b0, keep_r[MAX_K-1:1]};
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keep_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (load) begin
        keep_r <= load_keep;
      end else if (adv) begin
        keep_r <= keep_shift;
      end
      if (adv) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
    if (load) begin
      none_r <= load_none;
      rank_r <= '0;
    end else if (adv) begin
      rank_r <= rank_r + RANK_W'(1);
    end
    if (adv) begin
      value_r    <= none_r ? '0 : snap_r[0];
      out_rank_r <= rank_r;
      out_none_r <= none_r;
      out_last_r <= head_last;
    end
  end

  // The snapshot values shift toward the head as results leave.
  generate
    for (genvar i = 0; i < MAX_K; i++) begin : g_snap
      always_ff @(posedge clk) begin
        if (load) begin
          snap_r[i] <= load_value[i];
        end else if (adv) begin
          if (i == MAX_K - 1) begin
            snap_r[i] <= '0;
          end else begin
            snap_r[i] <= snap_r[(i == MAX_K - 1) ? i : i + 1];
          end
        end
      end
    end
  endgenerate

  assign out_valid          = out_valid_r;
  assign out_neighbor_value = value_r;
  assign out_neighbor_rank  = out_rank_r;
  assign out_none_found     = out_none_r;
  assign out_last_result    = out_last_r;

`ifndef SYNTHESIS
  a_load_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    load |-> !busy)
    else $error("snapshot loaded while results still pending");

  a_keep_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    (keep_r & (keep_r + MAX_K'(1))) == '0)
    else $error("snapshot keep bits are not a contiguous prefix");

  a_none_single: assert property (@(posedge clk) disable iff (!rst_n)
    (busy && none_r) |-> (keep_r == MAX_K'(1)))
    else $error("empty-frame marker with more than one pending result");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && head_last) |=> !busy || $past(load))
    else $error("results remain after the last beat");
`endif

endmodule

>>> hdl/window_k_nearest_valid_core.sv
// ----------------------------------------------------------------------------
// window_k_nearest_valid_core
// Finds the nearest valid neighbors of a target cell in a raster-scanned
// matrix and returns their values, nearest first, at the end of each frame.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive on the in_ channel, one beat per element in row-major order,
// with the last element of a frame flagged by in_frame_end. The block takes
// one pixel beat per cycle, bar the frame_end hold-off below. A pixel first
// goes through a qualification stage (window, target, missing and near-zero
// checks plus squared distance), then into a row of MAX_K list cells that
// insert it in sorted order. When a frame ends, the finished list is copied
// into a drain buffer and the list cells clear, so the next frame streams in
// at once. Results leave on the out_ channel, one beat per cycle while
// out_ready is high, and a frame yields between one and MAX_K result beats.
// If out_ready is low, results wait in the output register and drain buffer
// while pixels keep flowing; only a further frame_end beat is held off
// (in_ready low) until the earlier frame's results have all left the drain
// buffer. The cfg_ channel writes registers by index and is always ready.
// Reset (rst_n low, synchronous) empties the list, drain buffer and output
// register and loads the register defaults.
// ----------------------------------------------------------------------------
module window_k_nearest_valid_core #(
  parameter int MAX_K      = wknv_pkg::MAX_K_DEF,
  parameter int COORD_BITS = wknv_pkg::COORD_BITS_DEF,
  parameter int MAX_RADIUS = wknv_pkg::MAX_RADIUS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Configuration write channel.
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic [wknv_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [wknv_pkg::CFG_DATA_W-1:0]      cfg_data,
  // Pixel channel.
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [COORD_BITS-1:0]                in_pixel_row,
  input  logic [COORD_BITS-1:0]                in_pixel_col,
  input  logic signed [wknv_pkg::VALUE_W-1:0]  in_pixel_value,
  input  logic                                 in_pixel_missing,
  input  logic                                 in_frame_end,
  // Result channel.
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [wknv_pkg::VALUE_W-1:0]  out_neighbor_value,
  output logic [wknv_pkg::RANK_W-1:0]          out_neighbor_rank,
  output logic                                 out_none_found,
  output logic                                 out_last_result
);
  import wknv_pkg::*;

  localparam int CMP_W = (COORD_BITS > RADIUS_W) ? COORD_BITS : RADIUS_W;
  localparam int SQ_W  = 2 * RADIUS_W;

  // Configuration registers.
  logic [COORD_BITS-1:0] target_row_r;
  logic [COORD_BITS-1:0] target_col_r;
  logic [RADIUS_W-1:0]   search_radius_r;
  logic [COUNT_W-1:0]    neighbor_count_r;
  logic                  skip_zeros_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_row_r     <= '0;
      target_col_r     <= '0;
      search_radius_r  <= SEARCH_RADIUS_RST;
      neighbor_count_r <= NEIGHBOR_COUNT_RST;
      skip_zeros_r     <= 1'b1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_TARGET_ROW:     target_row_r     <= COORD_BITS'(cfg_data);
        REG_TARGET_COL:     target_col_r     <= COORD_BITS'(cfg_data);
        REG_SEARCH_RADIUS:  search_radius_r  <= cfg_data[RADIUS_W-1:0];
        REG_NEIGHBOR_COUNT: neighbor_count_r <= cfg_data[COUNT_W-1:0];
        REG_SKIP_ZEROS:     skip_zeros_r     <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Qualification front end. The window test bounds both offsets by the
  // radius, so the squares only need radius-wide operands.
  logic                       drain_busy;
  logic                       in_fire;
  logic [CMP_W-1:0]           row_x, col_x, trow_x, tcol_x;
  logic [CMP_W-1:0]           dr, dc, rad_x;
  logic [RADIUS_W-1:0]        radius;
  logic [SQ_W-1:0]            sq_r, sq_c;
  logic                       near_zero;
  logic                       qualify;

  logic                       s1_valid_r;
  logic                       s1_qual_r;
  logic                       s1_end_r;
  logic [DIST_W-1:0]          s1_dist_r;
  logic signed [VALUE_W-1:0]  s1_value_r;

  // A new frame end waits until the previous frame's results are out of the
  // drain buffer, counting one still in the front stage.
  assign in_ready = !(in_frame_end && (drain_busy || (s1_valid_r && s1_end_r)));
  assign in_fire  = in_valid && in_ready;

  assign radius = (32'(search_radius_r) > MAX_RADIUS) ? RADIUS_W'(MAX_RADIUS)
                                                      : search_radius_r;
  assign row_x  = CMP_W'(in_pixel_row);
  assign col_x  = CMP_W'(in_pixel_col);
  assign trow_x = CMP_W'(target_row_r);
  assign tcol_x = CMP_W'(target_col_r);
  assign rad_x  = CMP_W'(radius);
  assign dr     = (row_x > trow_x) ? row_x - trow_x : trow_x - row_x;
  assign dc     = (col_x > tcol_x) ? col_x - tcol_x : tcol_x - col_x;
  assign sq_r   = SQ_W'(dr[RADIUS_W-1:0]) * SQ_W'(dr[RADIUS_W-1:0]);
  assign sq_c   = SQ_W'(dc[RADIUS_W-1:0]) * SQ_W'(dc[RADIUS_W-1:0]);

  assign near_zero = (in_pixel_value < ZERO_LIMIT) && (in_pixel_value > -ZERO_LIMIT);
  assign qualify   = (dr <= rad_x) && (dc <= rad_x)
                  && !((dr == '0) && (dc == '0))
                  && !in_pixel_missing
                  && !(skip_zeros_r && near_zero);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= in_fire;
    end
    if (in_fire) begin
      s1_qual_r  <= qualify;
      s1_end_r   <= in_frame_end;
      s1_dist_r  <= DIST_W'(sq_r) + DIST_W'(sq_c);
      s1_value_r <= in_pixel_value;
    end
  end

  // Insertion chain. Each cell compares the candidate with its own entry;
  // the first cell that ranks after the candidate takes it, and every cell
  // behind that one takes its left neighbor's entry. The last entry falls
  // off a full list.
  logic   insert;
  logic   frame_done;
  entry_t cell_entry [MAX_K];
  entry_t cell_nxt   [MAX_K];
  logic   cell_goes  [MAX_K];
  logic [MAX_K-1:0]          keep;
  logic signed [VALUE_W-1:0] snap_value [MAX_K];

  assign insert     = s1_valid_r && s1_qual_r;
  assign frame_done = s1_valid_r && s1_end_r;

  generate
    for (genvar i = 0; i < MAX_K; i++) begin : g_cell
      entry_t left_entry;
      logic   left_goes;

      if (i == 0) begin : g_head
        assign left_entry = '0;
        assign left_goes  = 1'b0;
      end else begin : g_body
        assign left_entry = cell_entry[(i == 0) ? 0 : i - 1];
        assign left_goes  = cell_goes[(i == 0) ? 0 : i - 1];
      end

      wknv_cell u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .insert     (insert),
        .clear      (frame_done),
        .cand_dist  (s1_dist_r),
        .cand_value (s1_value_r),
        .left_entry (left_entry),
        .left_goes  (left_goes),
        .entry      (cell_entry[i]),
        .goes       (cell_goes[i]),
        .entry_nxt  (cell_nxt[i])
      );

      // Only the first neighbor_count entries are returned; a count of zero
      // still returns the nearest one.
      assign keep[i]       = cell_nxt[i].valid
                          && ((i == 0) || (32'(neighbor_count_r) > 32'(i)));
      assign snap_value[i] = cell_nxt[i].value;
    end
  endgenerate

  // An empty list at frame end yields a single result with none_found set.
  logic             list_empty;
  logic [MAX_K-1:0] load_keep;

  assign list_empty = !cell_nxt[0].valid;
  assign load_keep  = list_empty ? MAX_K'(1) : keep;

  wknv_drain #(
    .MAX_K (MAX_K)
  ) u_drain (
    .clk                (clk),
    .rst_n              (rst_n),
    .load               (frame_done),
    .load_keep          (load_keep),
    .load_value         (snap_value),
    .load_none          (list_empty),
    .busy               (drain_busy),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_neighbor_value (out_neighbor_value),
    .out_neighbor_rank  (out_neighbor_rank),
    .out_none_found     (out_none_found),
    .out_last_result    (out_last_result)
  );

`ifndef SYNTHESIS
  a_end_gate: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |-> !drain_busy)
    else $error("frame ended while the previous frame was still draining");

  a_list_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    !cell_entry[0].valid |-> !cell_nxt[MAX_K-1].valid || (MAX_K == 1))
    else $error("list filled out of order");

  a_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    frame_done |=> !cell_entry[0].valid)
    else $error("list not cleared after frame end");
`endif

endmodule

>>> tb/sv/window_k_nearest_valid_core_tb.sv
// ----------------------------------------------------------------------------
// window_k_nearest_valid_core_tb
// Self-checking testbench for the windowed nearest-neighbor search core.
// Pixel beats are driven with random gaps unless idle_on is clear. A
// scoreboard in the testbench keeps its own sorted neighbor list and register
// copy, and works out the result beats of every frame. Each result beat from
// the block is compared against the oldest expected beat, field by field.
// ----------------------------------------------------------------------------
module window_k_nearest_valid_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import wknv_pkg::*;

  localparam int CLK_PERIOD    = 20;
  localparam int LIST_DEPTH    = MAX_K_DEF;
  localparam int COORD_W       = COORD_BITS_DEF;
  // Raw Q16.16 magnitudes below this are treated as zero when zeros are skipped.
  localparam int NEAR_ZERO_MAG = 7;
  // The qualification stage and the list insertion are registered; this many
  // quiet cycles are enough for pixels without results to settle.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int RANDOM_PIXELS = 65;

  // One expected result beat.
  typedef struct {
    logic signed [VALUE_W-1:0] value;
    logic [RANK_W-1:0]         rank;
    logic                      none_found;
    logic                      last_result;
  } neighbor_beat_t;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  logic                      in_valid         = 1'b0;
  logic                      in_ready;
  logic [COORD_W-1:0]        in_pixel_row     = '0;
  logic [COORD_W-1:0]        in_pixel_col     = '0;
  logic signed [VALUE_W-1:0] in_pixel_value   = '0;
  logic                      in_pixel_missing = 1'b0;
  logic                      in_frame_end     = 1'b0;

  logic                      out_valid;
  logic                      out_ready = 1'b0;
  logic signed [VALUE_W-1:0] out_neighbor_value;
  logic [RANK_W-1:0]         out_neighbor_rank;
  logic                      out_none_found;
  logic                      out_last_result;

  // Scoreboard copy of the block's registers.
  logic [COORD_W-1:0]  tgt_row;
  logic [COORD_W-1:0]  tgt_col;
  logic [RADIUS_W-1:0] win_radius;
  logic [COUNT_W-1:0]  want_count;
  logic                drop_zeros;

  // Scoreboard copy of the sorted neighbor list.
  logic [DIST_W-1:0]         nb_dist  [LIST_DEPTH];
  logic signed [VALUE_W-1:0] nb_value [LIST_DEPTH];
  int                        nb_fill;

  neighbor_beat_t expected_neighbors[$];
  neighbor_beat_t want;

  int error_count      = 0;
  int pixels_sent      = 0;
  int cycle_count      = 0;
  // When clear, neither side inserts random idle cycles.
  bit idle_on          = 1'b1;
  // Set by a test to hold the result channel off for that many cycles.
  int sink_hold_cycles = 0;
  int sink_wait        = 0;

  window_k_nearest_valid_core DUT (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_pixel_row       (in_pixel_row),
    .in_pixel_col       (in_pixel_col),
    .in_pixel_value     (in_pixel_value),
    .in_pixel_missing   (in_pixel_missing),
    .in_frame_end       (in_frame_end),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_neighbor_value (out_neighbor_value),
    .out_neighbor_rank  (out_neighbor_rank),
    .out_none_found     (out_none_found),
    .out_last_result    (out_last_result)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Hard stop in case the block hangs or drops a result.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Scoreboard prediction. A pixel is a candidate when it lies inside the
  // square window around the target, is not the target itself, is not missing
  // and is not near zero while zeros are skipped. Candidates are inserted by
  // squared distance, after any entry at the same distance, and the farthest
  // entry falls off a full list. On the frame_end pixel (after that pixel has
  // been considered) the nearest entries are queued for checking and the list
  // is cleared; an empty list gives a single none_found beat.
  // --------------------------------------------------------------------------
  function automatic void predict_neighbors(input logic [COORD_W-1:0] row,
                                            input logic [COORD_W-1:0] col,
                                            input logic signed [VALUE_W-1:0] value,
                                            input logic missing,
                                            input logic frame_end);
    int                 dr;
    int                 dc;
    int                 pos;
    int                 tail;
    int                 limit;
    int                 n;
    logic [VALUE_W-1:0] mag;
    logic [DIST_W-1:0]  sq_dist;
    neighbor_beat_t     beat;

    dr      = (row > tgt_row) ? int'(row - tgt_row) : int'(tgt_row - row);
    dc      = (col > tgt_col) ? int'(col - tgt_col) : int'(tgt_col - col);
    mag     = value[VALUE_W-1] ? (VALUE_W'(0) - VALUE_W'(value)) : VALUE_W'(value);
    sq_dist = DIST_W'(dr * dr + dc * dc);

    if (dr <= win_radius && dc <= win_radius && !(dr == 0 && dc == 0) && !missing
        && !(drop_zeros && mag < NEAR_ZERO_MAG)) begin
      pos = 0;
      while (pos < nb_fill && nb_dist[pos] <= sq_dist) pos++;
      if (pos < LIST_DEPTH) begin
        tail = (nb_fill < LIST_DEPTH) ? nb_fill : LIST_DEPTH - 1;
        for (int i = tail; i > pos; i--) begin
          nb_dist[i]  = nb_dist[i-1];
          nb_value[i] = nb_value[i-1];
        end
        nb_dist[pos]  = sq_dist;
        nb_value[pos] = value;
        if (nb_fill < LIST_DEPTH) nb_fill++;
      end
    end

    if (!frame_end) return;

    if (nb_fill == 0) begin
      beat.value       = '0;
      beat.rank        = '0;
      beat.none_found  = 1'b1;
      beat.last_result = 1'b1;
      expected_neighbors.push_back(beat);
      return;
    end

    // A count of zero acts as one and anything above the list depth as the
    // full list.
    limit = (want_count < 1) ? 1 : int'(want_count);
    if (limit > LIST_DEPTH) limit = LIST_DEPTH;
    n = (nb_fill < limit) ? nb_fill : limit;
    for (int i = 0; i < n; i++) begin
      beat.value       = nb_value[i];
      beat.rank        = RANK_W'(i);
      beat.none_found  = 1'b0;
      beat.last_result = (i == n - 1);
      expected_neighbors.push_back(beat);
    end
    for (int i = 0; i < LIST_DEPTH; i++) begin
      nb_dist[i]  = '0;
      nb_value[i] = '0;
    end
    nb_fill = 0;
  endfunction

  // --------------------------------------------------------------------------
  // Beat monitor. Result beats are checked against the oldest expectation,
  // register writes update the scoreboard's copy, and accepted pixels are fed
  // to the predictor. Everything is sampled at the rising edge, where the
  // values seen are the ones that were stable during the preceding cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      tgt_row    = '0;
      tgt_col    = '0;
      win_radius = SEARCH_RADIUS_RST;
      want_count = NEIGHBOR_COUNT_RST;
      drop_zeros = 1'b1;
      for (int i = 0; i < LIST_DEPTH; i++) begin
        nb_dist[i]  = '0;
        nb_value[i] = '0;
      end
      nb_fill = 0;
    end else begin
      if (out_valid === 1'b1 && out_ready === 1'b1) begin
        if (expected_neighbors.size() == 0) begin
          $error("result beat with no expected result pending (value %0d, rank %0d)",
                 out_neighbor_value, out_neighbor_rank);
          error_count++;
        end else begin
          want = expected_neighbors.pop_front();
          if (out_neighbor_value !== want.value) begin
            $error("neighbor_value: expected %0d, got %0d", want.value, out_neighbor_value);
            error_count++;
          end
          if (out_neighbor_rank !== want.rank) begin
            $error("neighbor_rank: expected %0d, got %0d", want.rank, out_neighbor_rank);
            error_count++;
          end
          if (out_none_found !== want.none_found) begin
            $error("none_found: expected %0b, got %0b", want.none_found, out_none_found);
            error_count++;
          end
          if (out_last_result !== want.last_result) begin
            $error("last_result: expected %0b, got %0b", want.last_result, out_last_result);
            error_count++;
          end
        end
      end

      if (cfg_valid === 1'b1 && cfg_ready === 1'b1) begin
        case (cfg_index)
          REG_TARGET_ROW:     tgt_row    = cfg_data[COORD_W-1:0];
          REG_TARGET_COL:     tgt_col    = cfg_data[COORD_W-1:0];
          REG_SEARCH_RADIUS:  win_radius = cfg_data[RADIUS_W-1:0];
          REG_NEIGHBOR_COUNT: want_count = cfg_data[COUNT_W-1:0];
          REG_SKIP_ZEROS:     drop_zeros = cfg_data[0];
          default: ;
        endcase
      end

      if (in_valid === 1'b1 && in_ready === 1'b1)
        predict_neighbors(in_pixel_row, in_pixel_col, in_pixel_value,
                          in_pixel_missing, in_frame_end);
    end
  end

  // --------------------------------------------------------------------------
  // Result sink. After an accepted result beat it usually draws, while idle_on
  // is set, a random number of cycles to hold out_ready low. A test can also
  // request one long hold-off, which is counted down here cycle by cycle.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      sink_wait <= 0;
    end else if (sink_hold_cycles > 0) begin
      out_ready        <= 1'b0;
      sink_hold_cycles <= sink_hold_cycles - 1;
    end else if (!out_ready) begin
      if (sink_wait <= 1) out_ready <= 1'b1;
      sink_wait <= (sink_wait > 0) ? sink_wait - 1 : 0;
    end else if (out_valid === 1'b1) begin
      if (idle_on && $urandom_range(7, 0) > 0) begin
        out_ready <= 1'b0;
        sink_wait <= $urandom_range(7, 1);
      end
    end
  end

  // Offers one pixel beat after a random gap (none while idle_on is clear) and
  // returns at the edge where it is accepted. in_valid is left high so a
  // following beat can go out with no bubble; whoever stops sending lowers it.
  task automatic send_pixel(input logic [COORD_W-1:0] row, input logic [COORD_W-1:0] col,
                            input logic signed [VALUE_W-1:0] value,
                            input logic missing, input logic frame_end);
    int gap;
    gap = idle_on ? $urandom_range(7, 0) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_pixel_row     <= row;
    in_pixel_col     <= col;
    in_pixel_value   <= value;
    in_pixel_missing <= missing;
    in_frame_end     <= frame_end;
    do @(posedge clk); while (in_ready !== 1'b1);
    pixels_sent++;
  endtask

  // Stops sending and waits until every expected result has arrived, then lets
  // pixels that cause no result drain out of the pipeline.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_neighbors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Writes all five registers once the block is idle.
  task automatic configure(input logic [COORD_W-1:0] trow, input logic [COORD_W-1:0] tcol,
                           input logic [RADIUS_W-1:0] radius,
                           input logic [COUNT_W-1:0] count, input logic skip);
    logic [CFG_IDX_W-1:0]  index [5];
    logic [CFG_DATA_W-1:0] data  [5];
    index = '{REG_TARGET_ROW, REG_TARGET_COL, REG_SEARCH_RADIUS,
              REG_NEIGHBOR_COUNT, REG_SKIP_ZEROS};
    data  = '{CFG_DATA_W'(trow), CFG_DATA_W'(tcol), CFG_DATA_W'(radius),
              CFG_DATA_W'(count), CFG_DATA_W'(skip)};
    wait_idle();
    for (int i = 0; i < 5; i++) begin
      cfg_valid <= 1'b1;
      cfg_index <= index[i];
      cfg_data  <= data[i];
      do @(posedge clk); while (cfg_ready !== 1'b1);
    end
    cfg_valid <= 1'b0;
  endtask

  // A mix of near-zero raws, full-range words, extremes and plain Q16.16 values.
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] v;
    case ($urandom_range(4, 0))
      0: v = $signed($urandom_range(20, 0)) - 10;
      1: v = $urandom();
      2: begin
        case ($urandom_range(3, 0))
          0: v = 32'sh8000_0000;
          1: v = 32'sh7FFF_FFFF;
          2: v = -32'sd7;
          default: v = 32'sd7;
        endcase
      end
      default: v = ($signed($urandom_range(200, 0)) - 100) <<< 16;
    endcase
    return v;
  endfunction

  // Reset defaults: target (0,0), radius 8, four neighbors, zeros skipped. The
  // frame covers the target itself, near-zero raws on both sides of the
  // threshold, a missing pixel, the window corner and a pixel just outside,
  // and ends on a candidate. A lone frame_end on the target then checks the
  // nothing-found beat.
  task automatic test_reset_defaults();
    idle_on = 1'b1;
    send_pixel(10'd0, 10'd0, 32'sh0005_0000, 1'b0, 1'b0);
    send_pixel(10'd0, 10'd1, 32'sd6,         1'b0, 1'b0);
    send_pixel(10'd0, 10'd2, -32'sd6,        1'b0, 1'b0);
    send_pixel(10'd0, 10'd3, 32'sd7,         1'b0, 1'b0);
    send_pixel(10'd1, 10'd0, -32'sd7,        1'b0, 1'b0);
    send_pixel(10'd1, 10'd1, 32'sh0001_0000, 1'b1, 1'b0);
    send_pixel(10'd8, 10'd8, 32'sh7FFF_FFFF, 1'b0, 1'b0);
    send_pixel(10'd9, 10'd0, 32'sh0002_0000, 1'b0, 1'b0);
    send_pixel(10'd2, 10'd2, -32'sh0001_0000, 1'b0, 1'b1);
    send_pixel(10'd0, 10'd0, 32'sd0,         1'b0, 1'b1);
  endtask

  // Target in the far corner, widest window, a count above the list depth and
  // zeros kept. Nine candidates overflow the list so the farthest one drops,
  // two pairs tie on distance, and the frame ends on a missing pixel.
  task automatic test_extremes();
    configure(10'd1023, 10'd1023, 6'd63, 4'd15, 1'b0);
    send_pixel(10'd1023, 10'd1023, 32'sd0,          1'b0, 1'b0);
    send_pixel(10'd0,    10'd0,    32'sd5,          1'b0, 1'b0);
    send_pixel(10'd960,  10'd960,  32'sh8000_0000,  1'b0, 1'b0);
    send_pixel(10'd1023, 10'd960,  32'sd0,          1'b0, 1'b0);
    send_pixel(10'd1023, 10'd1022, 32'sd1,          1'b0, 1'b0);
    send_pixel(10'd1022, 10'd1023, -32'sd1,         1'b0, 1'b0);
    send_pixel(10'd1022, 10'd1022, 32'sh7FFF_FFFF,  1'b0, 1'b0);
    send_pixel(10'd1021, 10'd1023, 32'sd3,          1'b0, 1'b0);
    send_pixel(10'd1023, 10'd1021, 32'sd4,          1'b0, 1'b0);
    send_pixel(10'd1021, 10'd1021, 32'sh0123_4567,  1'b0, 1'b0);
    send_pixel(10'd1020, 10'd1023, -32'sh0765_4321, 1'b0, 1'b0);
    send_pixel(10'd1023, 10'd1022, 32'sh1234_5678,  1'b1, 1'b1);
  endtask

  // Radius zero admits nothing, so the first frame ends on the nothing-found beat.
  // Registers are also changed in the middle of a frame: the window opens after
  // a rejected pixel, then closes again with entries already in the list, which
  // must survive to the frame end.
  task automatic test_window_and_count_limits();
    configure(10'd5, 10'd5, 6'd0, 4'd0, 1'b1);
    send_pixel(10'd5, 10'd6, 32'sh0001_0000, 1'b0, 1'b0);
    send_pixel(10'd5, 10'd5, 32'sh0001_0000, 1'b0, 1'b1);
    send_pixel(10'd4, 10'd4, 32'sh0002_0000, 1'b0, 1'b0);
    configure(10'd5, 10'd5, 6'd1, 4'd0, 1'b1);
    send_pixel(10'd4, 10'd5, 32'sh0003_0000, 1'b0, 1'b0);
    send_pixel(10'd6, 10'd6, 32'sh0004_0000, 1'b0, 1'b0);
    configure(10'd5, 10'd5, 6'd0, 4'd2, 1'b1);
    send_pixel(10'd5, 10'd4, 32'sh0005_0000, 1'b0, 1'b1);
  endtask

  // Random frames: small raster scans around a random target, with noise
  // pixels mixed in and now and then a frame cut short by an early frame_end.
  // Registers are redrawn every few frames, always with the block idle.
  task automatic test_random_frames();
    int                  first_pixel;
    int                  frames;
    int                  rows;
    int                  cols;
    int                  cut;
    int                  idx;
    bit                  done;
    logic [COORD_W-1:0]  trow;
    logic [COORD_W-1:0]  tcol;
    logic [COORD_W-1:0]  row0;
    logic [COORD_W-1:0]  col0;
    logic [RADIUS_W-1:0] radius;
    first_pixel = pixels_sent;
    frames      = 0;
    trow        = '0;
    tcol        = '0;
    while (pixels_sent - first_pixel < RANDOM_PIXELS) begin
      if (frames % 3 == 0) begin
        trow = COORD_W'($urandom_range(1023, 0));
        tcol = COORD_W'($urandom_range(1023, 0));
        case ($urandom_range(3, 0))
          0: radius = 6'd63;
          1: radius = RADIUS_W'($urandom_range(63, 0));
          default: radius = RADIUS_W'($urandom_range(3, 0));
        endcase
        configure(trow, tcol, radius, COUNT_W'($urandom_range(15, 0)),
                  1'($urandom_range(1, 0)));
      end
      idle_on = ($urandom_range(3, 0) != 0);
      rows    = $urandom_range(4, 1);
      cols    = $urandom_range(5, 1);
      row0    = trow - COORD_W'($urandom_range(rows - 1, 0));
      col0    = tcol - COORD_W'($urandom_range(cols - 1, 0));
      cut     = ($urandom_range(7, 0) == 0) ? $urandom_range(rows * cols - 1, 0)
                                            : rows * cols - 1;
      done    = 1'b0;
      for (int r = 0; r < rows; r++) begin
        for (int c = 0; c < cols; c++) begin
          idx = r * cols + c;
          if (!done) begin
            if ($urandom_range(9, 0) == 0)
              send_pixel(COORD_W'($urandom_range(1023, 0)), COORD_W'($urandom_range(1023, 0)),
                         $urandom(), 1'($urandom_range(1, 0)), 1'b0);
            send_pixel(row0 + COORD_W'(r), col0 + COORD_W'(c), pick_value(),
                       ($urandom_range(9, 0) == 0), (idx == cut));
            done = (idx == cut);
          end
        end
      end
      frames++;
    end
    idle_on = 1'b1;
  endtask

  // The sink holds off for a long stretch while full frames keep coming with
  // no gaps. The block parks one frame's results, so the next frame_end beat
  // must be stalled on in_ready until the sink drains.
  task automatic test_output_backpressure();
    configure(10'd100, 10'd200, 6'd2, 4'd8, 1'b0);
    idle_on = 1'b0;
    sink_hold_cycles <= 300;
    for (int f = 0; f < 4; f++) begin
      for (int r = 99; r <= 101; r++) begin
        for (int c = 199; c <= 201; c++)
          send_pixel(COORD_W'(r), COORD_W'(c), $urandom(), 1'b0, (r == 101 && c == 201));
      end
    end
    idle_on = 1'b1;
    wait_idle();
  endtask

  // --------------------------------------------------------------------------
  // Test sequence. Reset is held at the start, then each test runs in turn.
  // Tests that change registers wait for all results first, which also gives
  // the sender pauses until the result queue is empty.
  // --------------------------------------------------------------------------
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_extremes();
    test_window_and_count_limits();
    test_output_backpressure();
    test_random_frames();

    wait_idle();
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/wknv_pkg.sv
hdl/wknv_cell.sv
hdl/wknv_drain.sv
hdl/window_k_nearest_valid_core.sv
tb/sv/window_k_nearest_valid_core_tb.sv
